// ----- sv/assert_macros.svh -----
// Assertion macros used by the converter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, pre, post, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// ----- sv/ryc_pkg.sv -----
// Types, widths and coefficient matrices of the RGB/YIQ converter
package ryc_pkg;

   localparam int COMP_W     = 18;
   localparam int COEF_W     = 16;
   localparam int PROD_W     = COMP_W + COEF_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int FRAC_SHIFT = 14;
   localparam int QUOT_W     = SUM_W - FRAC_SHIFT;
   localparam int BYTE_W     = 8;
   localparam int NUM_COMP   = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic signed [COMP_W-1:0] comp_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef logic signed [QUOT_W-1:0] quot_type;
   typedef logic [BYTE_W-1:0]        byte_type;

   typedef coef_type matrix_type [NUM_COMP][NUM_COMP];

   typedef enum logic {
      DIR_TO_YIQ = 1'b0,
      DIR_TO_RGB = 1'b1
   } dir_type;

   localparam logic REG_DIRECTION = 1'b0;

   localparam matrix_type TO_YIQ = '{
      '{ 16'sd4899,  16'sd9617,  16'sd1868},
      '{ 16'sd9760, -16'sd4497, -16'sd5264},
      '{ 16'sd3464, -16'sd8562,  16'sd5098}
   };

   localparam matrix_type TO_RGB = '{
      '{16'sd16384,  16'sd15668,  16'sd10174},
      '{16'sd16384, -16'sd4458,  -16'sd10607},
      '{16'sd16384, -16'sd18137,  16'sd27928}
   };

   localparam sum_type  ROUND_BIAS = sum_type'(2 ** (FRAC_SHIFT - 1));
   localparam quot_type OUT_MAX    = quot_type'((2 ** (COMP_W - 1)) - 1);
   localparam quot_type OUT_MIN    = quot_type'(-(2 ** (COMP_W - 1)));
   localparam comp_type BYTE_TOP   = comp_type'(255 * 256);
   localparam byte_type BYTE_MAX   = byte_type'(255);

endpackage

// ----- sv/rgb_yiq_color_converter.sv -----
// Pixel converter between RGB and YIQ in Q10.8 with Q2.14 matrix coefficients.
// Pixels pass a multiply, an add and an output register, one pixel per clock
// sustained while rsp_tready is high: the multiply register holds nine 18x16
// products, the add register the three rounded row sums, the output register
// the saturated and byte-clamped results. Each register advances on its own
// when the next one is empty or moving, so bubbles close up under backpressure.
// The direction register (addresses 0 to 3, bit 0: 0 RGB to YIQ, 1 YIQ to RGB)
// is sampled as a pixel enters; change it only while the pipeline is empty.
`include "assert_macros.svh"

module rgb_yiq_color_converter
   import ryc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [17:0] first_component, [35:18] second_component, [53:36] third_component
   input  logic [55:0]           req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [17:0] out_first, [35:18] out_second, [53:36] out_third,
   // [61:54] first_byte, [69:62] second_byte, [77:70] third_byte
   output logic [79:0]           rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   dir_type  dir_ff, dir_in;
   logic     csr_write;

   logic     mul_valid_ff, add_valid_ff, out_valid_ff;
   logic     mul_last_ff, add_last_ff, out_last_ff;
   logic     mul_en, add_en, out_en;

   comp_type comp      [NUM_COMP];
   prod_type prod_in   [NUM_COMP][NUM_COMP];
   prod_type prod_ff   [NUM_COMP][NUM_COMP];
   sum_type  sum_in    [NUM_COMP];
   sum_type  sum_ff    [NUM_COMP];
   comp_type res_in    [NUM_COMP];
   comp_type res_ff    [NUM_COMP];
   byte_type byte_in   [NUM_COMP];
   byte_type byte_ff   [NUM_COMP];

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[CSR_ADDR_W-1] == REG_DIRECTION);
   assign csr_prdata = {{(CSR_DATA_W-1){1'b0}}, dir_ff};

   always_comb begin
      dir_in = dir_ff;
      if (csr_write) begin
         dir_in = dir_type'(csr_pwdata[0]);
      end
   end

   // pipeline flow control
   assign out_en     = !out_valid_ff || rsp_tready;
   assign add_en     = !add_valid_ff || out_en;
   assign mul_en     = !mul_valid_ff || add_en;
   assign req_tready = mul_en;

   assign comp[0] = comp_type'(req_tdata[COMP_W-1:0]);
   assign comp[1] = comp_type'(req_tdata[2*COMP_W-1:COMP_W]);
   assign comp[2] = comp_type'(req_tdata[3*COMP_W-1:2*COMP_W]);

   always_comb begin
      for (int r = 0; r < NUM_COMP; r++) begin
         for (int c = 0; c < NUM_COMP; c++) begin
            if (dir_ff == DIR_TO_RGB) begin
               prod_in[r][c] = prod_type'(TO_RGB[r][c]) * prod_type'(comp[c]);
            end else begin
               prod_in[r][c] = prod_type'(TO_YIQ[r][c]) * prod_type'(comp[c]);
            end
         end
      end
   end

   always_comb begin
      for (int r = 0; r < NUM_COMP; r++) begin
         sum_in[r] = sum_type'(prod_ff[r][0]) + sum_type'(prod_ff[r][1])
                   + sum_type'(prod_ff[r][2]) + ROUND_BIAS;
      end
   end

   always_comb begin
      quot_type q;
      for (int r = 0; r < NUM_COMP; r++) begin
         q = quot_type'(sum_ff[r][SUM_W-1:FRAC_SHIFT]);
         if (q > OUT_MAX) begin
            res_in[r] = comp_type'(OUT_MAX);
         end else if (q < OUT_MIN) begin
            res_in[r] = comp_type'(OUT_MIN);
         end else begin
            res_in[r] = comp_type'(q);
         end
         if (res_in[r] < 0) begin
            byte_in[r] = '0;
         end else if (res_in[r] >= BYTE_TOP) begin
            byte_in[r] = BYTE_MAX;
         end else begin
            byte_in[r] = res_in[r][BYTE_W+7:8];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff       <= DIR_TO_YIQ;
         mul_valid_ff <= 1'b0;
         add_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         dir_ff <= dir_in;
         if (mul_en) begin
            mul_valid_ff <= req_tvalid;
         end
         if (add_en) begin
            add_valid_ff <= mul_valid_ff;
         end
         if (out_en) begin
            out_valid_ff <= add_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff     <= prod_in;
         mul_last_ff <= req_tlast;
      end
      if (add_en) begin
         sum_ff      <= sum_in;
         add_last_ff <= mul_last_ff;
      end
      if (out_en) begin
         res_ff      <= res_in;
         byte_ff     <= byte_in;
         out_last_ff <= add_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {2'b00, byte_ff[2], byte_ff[1], byte_ff[0],
                        res_ff[2], res_ff[1], res_ff[0]};

   `ASSERT_NEXT(a_accept_fills, clock, reset, req_tvalid && req_tready, mul_valid_ff, "accepted beat dropped")
   `ASSERT_NEXT(a_held_result, clock, reset, out_valid_ff && !rsp_tready, out_valid_ff && $stable(res_ff[0]), "waiting result lost")
   `ASSERT_IMPLY(a_byte_neg, clock, reset, out_valid_ff && res_ff[0][COMP_W-1], byte_ff[0] == '0, "negative result gives nonzero byte")

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the RGB/YIQ pixel converter with stream and APB ports
module tb
   import ryc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 4000;
   localparam int RANDOM_PER_SETTING = 75;
   localparam logic [CSR_ADDR_W-1:0] DIRECTION_ADDR = CSR_ADDR_W'(4 * REG_DIRECTION);
   localparam logic [CSR_ADDR_W-1:0] UNUSED_ADDR = CSR_ADDR_W'(4);
   localparam comp_type COMP_MAX = comp_type'(131071);
   localparam comp_type COMP_MIN = comp_type'(-131072);

   typedef struct packed {
      comp_type c0;
      comp_type c1;
      comp_type c2;
      logic     last;
      logic     drain;
   } pixel_type;

   typedef struct packed {
      comp_type y0;
      comp_type y1;
      comp_type y2;
      byte_type b0;
      byte_type b1;
      byte_type b2;
      logic     last;
   } converted_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // [17:0] first_component, [35:18] second_component, [53:36] third_component
   logic [55:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // [17:0] out_first, [35:18] out_second, [53:36] out_third,
   // [61:54] first_byte, [69:62] second_byte, [77:70] third_byte
   logic [79:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   int to_yiq_coef [9] = '{4899, 9617, 1868, 9760, -4497, -5264, 3464, -8562, 5098};
   int to_rgb_coef [9] = '{16384, 15668, 10174, 16384, -4458, -10607, 16384, -18137, 27928};

   dir_type       cur_dir = DIR_TO_YIQ;
   pixel_type     pending_q [$];
   converted_type converted_q [$];
   int            n_req = 0;
   int            n_rsp = 0;
   int            errors = 0;
   int            idle_cycles = 0;

   rgb_yiq_color_converter i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   function automatic converted_type convert_pixel(input dir_type dir, input pixel_type p);
      longint x [3];
      longint acc;
      longint q;
      int coef;
      converted_type r;
      comp_type y [3];
      byte_type b [3];
      x[0] = longint'(p.c0);
      x[1] = longint'(p.c1);
      x[2] = longint'(p.c2);
      for (int row = 0; row < 3; row++) begin
         acc = 0;
         for (int col = 0; col < 3; col++) begin
            coef = (dir == DIR_TO_RGB) ? to_rgb_coef[3*row+col] : to_yiq_coef[3*row+col];
            acc += longint'(coef) * x[col];
         end
         q = (acc + 8192) >>> 14;
         if (q < longint'(COMP_MIN)) q = longint'(COMP_MIN);
         if (q > longint'(COMP_MAX)) q = longint'(COMP_MAX);
         y[row] = comp_type'(q);
         if (q < 0) b[row] = '0;
         else if (q >= longint'(BYTE_TOP)) b[row] = BYTE_MAX;
         else b[row] = byte_type'(q >>> 8);
      end
      r.y0 = y[0];
      r.y1 = y[1];
      r.y2 = y[2];
      r.b0 = b[0];
      r.b1 = b[1];
      r.b2 = b[2];
      r.last = p.last;
      return r;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // sender: bursts of random length separated by random gaps
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin : drive_req
      logic fire;
      logic hold;
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tlast <= 1'b0;
      end else begin
         fire = req_tvalid && req_tready;
         hold = req_tvalid && !req_tready;
         if (fire) begin
            converted_q.push_back(convert_pixel(cur_dir, pending_q.pop_front()));
            n_req <= n_req + 1;
         end
         offer = hold;
         if (!hold) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_q.size() > 0 &&
                         (!pending_q[0].drain || (!fire && n_req == n_rsp))) begin
               offer = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
         req_tvalid <= offer;
         if (offer && !hold) begin
            req_tdata <= {2'b00, pending_q[0].c2, pending_q[0].c1, pending_q[0].c0};
            req_tlast <= pending_q[0].last;
         end
      end
   end

   // receiver: random stall pattern, plus long hold-offs at fixed beat counts
   int rsp_seen = 0;
   int stall_left = 0;
   int rx_cycle = 0;
   int rx_mode = 0;

   always @(posedge clock) begin : watch_rsp
      converted_type want;
      logic ready;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_rsp <= n_rsp + 1;
            rsp_seen++;
            if (converted_q.size() == 0) begin
               $display("%0t: beat expected none, actual %h", $time, rsp_tdata);
               errors++;
            end else begin
               want = converted_q.pop_front();
               check_field("out_first", longint'(want.y0),
                           longint'($signed(rsp_tdata[17:0])));
               check_field("out_second", longint'(want.y1),
                           longint'($signed(rsp_tdata[35:18])));
               check_field("out_third", longint'(want.y2),
                           longint'($signed(rsp_tdata[53:36])));
               check_field("first_byte", longint'(want.b0), longint'(rsp_tdata[61:54]));
               check_field("second_byte", longint'(want.b1), longint'(rsp_tdata[69:62]));
               check_field("third_byte", longint'(want.b2), longint'(rsp_tdata[77:70]));
               check_field("last_out", longint'(want.last), longint'(rsp_tlast));
            end
            if (rsp_seen == 100 || rsp_seen == 300) stall_left = 80;
         end
         rx_cycle++;
         if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
         if (stall_left > 0) begin
            stall_left--;
            ready = 1'b0;
         end else begin
            case (rx_mode)
               0: ready = 1'b1;
               1: ready = 1'($urandom_range(0, 1));
               2: ready = ($urandom_range(0, 3) != 0);
               default: ready = ($urandom_range(0, 7) == 0);
            endcase
         end
         rsp_tready <= ready;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
         $display("rgb_yiq_color_converter test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == DIRECTION_ADDR) cur_dir = dir_type'(data[0]);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_q.size() != 0 || req_tvalid || n_req != n_rsp);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_pixel(input comp_type c0, input comp_type c1, input comp_type c2,
                            input logic last, input logic drain);
      pixel_type p;
      p.c0 = c0;
      p.c1 = c1;
      p.c2 = c2;
      p.last = last;
      p.drain = drain;
      pending_q.push_back(p);
   endtask

   task automatic run_directed();
      add_pixel('0, '0, '0, 1'b0, 1'b0);
      add_pixel(COMP_MAX, COMP_MAX, COMP_MAX, 1'b0, 1'b0);
      add_pixel(COMP_MIN, COMP_MIN, COMP_MIN, 1'b1, 1'b0);
      add_pixel(COMP_MAX, COMP_MIN, COMP_MAX, 1'b0, 1'b0);
      add_pixel(COMP_MIN, COMP_MAX, COMP_MIN, 1'b0, 1'b0);
      add_pixel(BYTE_TOP, BYTE_TOP, BYTE_TOP, 1'b0, 1'b0);
      add_pixel(comp_type'(BYTE_TOP - 1), comp_type'(256), comp_type'(255), 1'b0, 1'b0);
      add_pixel(comp_type'(-1), comp_type'(-1), comp_type'(-1), 1'b0, 1'b0);
      add_pixel(comp_type'(1), '0, comp_type'(-1), 1'b0, 1'b0);
      add_pixel(comp_type'(65535), '0, comp_type'(65535), 1'b1, 1'b0);
      add_pixel(COMP_MAX, '0, COMP_MIN, 1'b0, 1'b1);
   endtask

   function automatic comp_type random_comp();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return comp_type'($urandom_range(0, 65535));
         5, 6: return comp_type'($urandom);
         7: begin
            case ($urandom_range(0, 5))
               0: return COMP_MAX;
               1: return COMP_MIN;
               2: return '0;
               3: return comp_type'(-1);
               4: return BYTE_TOP;
               default: return comp_type'(BYTE_TOP - 1);
            endcase
         end
         default: return comp_type'(int'($urandom_range(0, 2047)) - 1024);
      endcase
   endfunction

   task automatic run_random(input int count);
      repeat (count) begin
         add_pixel(random_comp(), random_comp(), random_comp(),
                   $urandom_range(0, 15) == 0, $urandom_range(0, 63) == 0);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_random(RANDOM_PER_SETTING);
      wait_drained();

      csr_write(DIRECTION_ADDR, CSR_DATA_W'(DIR_TO_RGB));
      run_directed();
      run_random(RANDOM_PER_SETTING);
      wait_drained();

      // upper bits of the direction value carry no meaning
      csr_write(DIRECTION_ADDR, 32'hFFFF_FFFE);
      run_random(RANDOM_PER_SETTING);
      wait_drained();

      csr_write(DIRECTION_ADDR, 32'h0000_0003);
      run_random(RANDOM_PER_SETTING);
      wait_drained();

      // an unmapped address leaves the direction alone
      csr_write(UNUSED_ADDR, CSR_DATA_W'(DIR_TO_YIQ));
      run_random(RANDOM_PER_SETTING);
      wait_drained();

      csr_write(DIRECTION_ADDR, CSR_DATA_W'(DIR_TO_YIQ));
      run_random(RANDOM_PER_SETTING);
      wait_drained();

      repeat (8) @(posedge clock);
      if (errors == 0 && converted_q.size() == 0) begin
         $display("rgb_yiq_color_converter test passed");
      end else begin
         $display("rgb_yiq_color_converter test failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/ryc_pkg.sv
sv/rgb_yiq_color_converter.sv
test/tb.sv
